// ----- rtl/mccv_pkg.sv -----
// shared types, status codes and preset tables for the midi control-voltage parser
// no dependencies
package mccv_pkg;

    localparam logic [3:0] STAT_NONE       = 4'h0;
    localparam logic [3:0] STAT_NOTE_OFF   = 4'h8;
    localparam logic [3:0] STAT_NOTE_ON    = 4'h9;
    localparam logic [3:0] STAT_POLY_PRESS = 4'hA;
    localparam logic [3:0] STAT_CTRL       = 4'hB;
    localparam logic [3:0] STAT_PROG       = 4'hC;
    localparam logic [3:0] STAT_CHAN_PRESS = 4'hD;
    localparam logic [3:0] STAT_BEND       = 4'hE;
    localparam logic [3:0] STAT_SYSTEM     = 4'hF;

    localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
    localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
    localparam logic [7:0] BYTE_REALTIME    = 8'hF8;

    localparam logic [2:0] CC_BANK      = 3'b010;
    localparam logic [2:0] PRESET_LAST  = 3'd7;
    localparam logic [7:0] CV_FULL      = 8'd255;
    localparam logic [7:0] CV_HALF      = 8'd128;
    localparam logic [7:0] CV_ZERO      = 8'd0;

    typedef struct packed {
        logic       is_preset;
        logic [3:0] tgt;
        logic [7:0] val;
    } t_cmd;

    typedef struct packed {
        logic [3:0] tgt;
        logic [7:0] val;
        logic       last;
    } t_cv_write;

    function automatic logic [3:0] preset_tgt(input logic [1:0] idx, input logic [2:0] step);
        logic [3:0] r;
        if (idx == 2'd0) begin
            r = {1'b1, step};
        end else if (step[0]) begin
            r = {2'b00, step[2:1]};
        end else begin
            r = {2'b01, step[2:1]};
        end
        return r;
    endfunction

    function automatic logic [7:0] preset_val(input logic [1:0] idx, input logic [2:0] step);
        logic [7:0] r;
        case (idx)
            2'd1: r = step[0] ? CV_FULL : CV_HALF;
            2'd2: r = (step[1:0] == 2'b00) ? CV_ZERO : CV_FULL;
            default: r = CV_FULL;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/mccv_front.sv -----
// byte parser: sysex and running status tracking, classifies bytes into write commands
// depends on mccv_pkg
module mccv_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [3:0]     i_cfg_wdata,
    input  logic           i_push,
    input  logic [7:0]     i_midi_byte,
    input  logic           i_cmd_full,
    output logic           o_cmd_push,
    output mccv_pkg::t_cmd o_cmd
);
    import mccv_pkg::*;

    logic [3:0] r_listen_ch;
    logic       r_sysex_open, n_sysex_open;
    logic [3:0] r_status, n_status;
    logic [3:0] r_channel, n_channel;
    logic       r_data_count, n_data_count;
    logic [6:0] r_first_data, n_first_data;
    logic       w_accept;
    logic       w_on_chan;

    assign w_accept  = i_push && !i_cmd_full;
    assign w_on_chan = (r_channel == r_listen_ch);

    always_comb begin
        n_sysex_open = r_sysex_open;
        n_status     = r_status;
        n_channel    = r_channel;
        n_data_count = r_data_count;
        n_first_data = r_first_data;
        o_cmd_push   = 1'b0;
        o_cmd        = '{is_preset: 1'b0, tgt: r_first_data[3:0],
                         val: {i_midi_byte[6:0], 1'b0}};
        if (w_accept) begin
            if (i_midi_byte == BYTE_SYSEX_START) begin
                n_sysex_open = 1'b1;
            end else if (i_midi_byte == BYTE_SYSEX_END) begin
                n_sysex_open = 1'b0;
            end else if (i_midi_byte >= BYTE_REALTIME || r_sysex_open) begin
                n_sysex_open = r_sysex_open;
            end else if (i_midi_byte[7]) begin
                n_status     = i_midi_byte[7:4];
                n_channel    = i_midi_byte[3:0];
                n_data_count = 1'b0;
            end else begin
                unique case (r_status) inside
                    STAT_NOTE_OFF, STAT_NOTE_ON, STAT_POLY_PRESS, STAT_CTRL, STAT_BEND: begin
                        if (!r_data_count) begin
                            n_first_data = i_midi_byte[6:0];
                            n_data_count = 1'b1;
                        end else begin
                            n_data_count = 1'b0;
                            if (r_status == STAT_CTRL && w_on_chan
                                && r_first_data[6:4] == CC_BANK) begin
                                o_cmd_push = 1'b1;
                            end
                        end
                    end
                    STAT_PROG: begin
                        n_data_count = 1'b0;
                        o_cmd.is_preset = 1'b1;
                        o_cmd.tgt = {2'b00, i_midi_byte[1:0]};
                        if (w_on_chan && i_midi_byte[6:2] == 5'd0
                            && i_midi_byte[1:0] != 2'b11) begin
                            o_cmd_push = 1'b1;
                        end
                    end
                    STAT_CHAN_PRESS: begin
                        n_data_count = 1'b0;
                    end
                    default: begin
                        n_data_count = r_data_count;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen_ch  <= 4'd0;
            r_sysex_open <= 1'b0;
            r_status     <= STAT_NONE;
            r_channel    <= 4'd0;
            r_data_count <= 1'b0;
            r_first_data <= 7'd0;
        end else begin
            if (i_cfg_we) begin
                r_listen_ch <= i_cfg_wdata;
            end
            r_sysex_open <= n_sysex_open;
            r_status     <= n_status;
            r_channel    <= n_channel;
            r_data_count <= n_data_count;
            r_first_data <= n_first_data;
        end
    end

endmodule

// ----- rtl/mccv_cmd_fifo.sv -----
// short command queue between parser and write sequencer
// depends on mccv_pkg
module mccv_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mccv_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output mccv_pkg::t_cmd o_cmd
);
    import mccv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_cmd     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/mccv_back.sv -----
// write sequencer: expands commands into control-voltage writes, holds the output register
// depends on mccv_pkg
module mccv_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_empty,
    input  mccv_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output mccv_pkg::t_cv_write o_write
);
    import mccv_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_PRESET = 2'b10
    } t_state;

    t_state    r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    t_cv_write  r_out, n_out;
    logic       w_adv;

    assign w_adv   = !r_out_valid || i_pop;
    assign o_empty = !r_out_valid;
    assign o_write = r_out;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        if (w_adv) begin
            n_out_valid = 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_cmd_empty) begin
                        o_cmd_pop   = 1'b1;
                        n_out_valid = 1'b1;
                        if (i_cmd.is_preset) begin
                            n_idx   = i_cmd.tgt[1:0];
                            n_step  = 3'd1;
                            n_state = ST_PRESET;
                            n_out   = '{tgt: preset_tgt(i_cmd.tgt[1:0], 3'd0),
                                        val: preset_val(i_cmd.tgt[1:0], 3'd0),
                                        last: 1'b0};
                        end else begin
                            n_out = '{tgt: i_cmd.tgt, val: i_cmd.val, last: 1'b1};
                        end
                    end
                end
                ST_PRESET: begin
                    n_out_valid = 1'b1;
                    n_out = '{tgt: preset_tgt(r_idx, r_step),
                              val: preset_val(r_idx, r_step),
                              last: (r_step == PRESET_LAST)};
                    n_step = r_step + 3'd1;
                    if (r_step == PRESET_LAST) begin
                        n_state = ST_IDLE;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_idx  <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    a_mid_write_in_preset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_state == ST_PRESET))
        else $error("non-final write outside preset sequence");

    a_preset_keeps_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PRESET) |-> r_out_valid)
        else $error("preset sequence without pending write");

    a_step_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PRESET && w_adv && r_step != PRESET_LAST)
            |=> (r_step == $past(r_step) + 3'd1))
        else $error("preset step did not advance");

endmodule

// ----- rtl/midi_cc_to_cv_parser.sv -----
// top level: midi byte parser feeding control-voltage writes through a command queue
// depends on mccv_pkg, mccv_front, mccv_cmd_fifo, mccv_back
//
// channel   direction  handshake                    payload
// bytes     in         i_push / o_full              i_midi_byte
// writes    out        o_empty / i_pop              o_cv_target, o_cv_value, o_last_write
// config    in         i_cfg_we                     i_cfg_wdata (listen channel)
//
// one byte a cycle is accepted while the command queue has room
// a listen-channel cc 32..47 gives one write, program 0..2 eight, one per cycle while popped
// the output register reloads in the cycle its write is popped
// synchronous active-low reset clears parser state, the queue and the write sequencer
module midi_cc_to_cv_parser #(
    parameter int CMD_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_midi_byte,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [3:0] o_cv_target,
    output logic [7:0] o_cv_value,
    output logic       o_last_write
);
    import mccv_pkg::*;

    logic      w_cmd_push, w_cmd_pop, w_cmd_empty;
    t_cmd      w_cmd_in, w_cmd_out;
    t_cv_write w_write;

    mccv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (i_push),
        .i_midi_byte (i_midi_byte),
        .i_cmd_full  (o_full),
        .o_cmd_push  (w_cmd_push),
        .o_cmd       (w_cmd_in)
    );

    mccv_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd_in),
        .o_full  (o_full),
        .i_pop   (w_cmd_pop),
        .o_empty (w_cmd_empty),
        .o_cmd   (w_cmd_out)
    );

    mccv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_write     (w_write)
    );

    assign o_cv_target  = w_write.tgt;
    assign o_cv_value   = w_write.val;
    assign o_last_write = w_write.last;

endmodule
